/* sv/bei_pkg.sv */
// Shared types and constants for the breakpoint envelope interpolator.
package bei_pkg;

  localparam int FRAME_W = 32;
  localparam int LEVEL_W = 32;
  localparam int COUNT_W = 5;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 32;
  localparam int DIV_W   = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ANCHOR = 1'b1;

  localparam logic [0:0] CFG_ANCHOR_COUNT = 1'b0;
  localparam logic [0:0] CFG_FRAME_OFFSET = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_PREV,
    S_WALK,
    S_NEXT,
    S_MUL1,
    S_MUL2,
    S_DSTART,
    S_DIV,
    S_FIX,
    S_ADJ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* sv/bei_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
module bei_divider import bei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2*DIV_W-1:0]   dividend,
  input  logic [DIV_W-1:0]     divisor,
  output logic [DIV_W-1:0]     quotient,
  output logic [DIV_W-1:0]     remainder,
  output div_status_t          status
);

  localparam int CW = $clog2(DIV_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(DIV_W - 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  // caller keeps the upper half of the dividend below the divisor,
  // so the quotient fits in DIV_W bits
  assign rem_sh = {rem, quo[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*DIV_W-1:DIV_W];
      quo <= dividend[DIV_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

/* sv/breakpoint_envelope_interpolator.sv */
// Top level: piecewise-linear breakpoint envelope with forward cursor walk.
//
//  channel | signals                                       | moves
//  --------+-----------------------------------------------+-------------------------
//  cfg     | cfg_write, cfg_index, cfg_data                | register write
//  in      | in_valid, in_stall, operation .. anchor_value | sample request / anchor
//  out     | out_valid, out_stall, level                   | one level word
//
// Anchor write: accepted while idle, no output word.
// Sample: the cursor walks past anchors through the single read port of the
// anchor table; the level is then held, or interpolated with the 32-step divider.
// Reset clears control state only; the anchor table holds garbage until written.
// Output register: a new request is taken while the last level still waits.
module breakpoint_envelope_interpolator import bei_pkg::*; #(
  parameter int MAX_ANCHORS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic signed [FRAME_W-1:0] frame,
  input  logic                      block_start,
  input  logic [SLOT_W-1:0]         anchor_index,
  input  logic signed [FRAME_W-1:0] anchor_frame,
  input  logic signed [LEVEL_W-1:0] anchor_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [LEVEL_W-1:0] level
);

  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int COUNT_TOP = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX =
    COUNT_W'((MAX_ANCHORS > COUNT_TOP) ? COUNT_TOP : MAX_ANCHORS);

  state_t state, state_next;

  logic [COUNT_W-1:0]        anchor_count;
  logic [COUNT_W-1:0]        cfg_count;
  logic signed [FRAME_W-1:0] frame_offset;
  logic [COUNT_W-1:0]        cursor_prev, cursor_prev_next;
  logic [COUNT_W-1:0]        cursor_next, cursor_next_next;
  logic                      have_history;
  logic [FRAME_W-1:0]        expected_frame;

  logic in_accept;
  logic out_accept;
  logic out_load;

  // anchor table
  logic signed [FRAME_W-1:0] mem_frame [MAX_ANCHORS];
  logic signed [LEVEL_W-1:0] mem_level [MAX_ANCHORS];
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [FRAME_W-1:0] rd_frame;
  logic signed [LEVEL_W-1:0] rd_level;
  logic signed [FRAME_W:0]   rd_frame_x;

  // datapath
  logic signed [FRAME_W:0]   env;
  logic signed [FRAME_W-1:0] fp, fn;
  logic signed [LEVEL_W-1:0] lp, ln;
  logic                      neg;
  logic [DIV_W-1:0]          mag, num, den;
  logic [2*DIV_W-1:0]        prod;
  logic signed [LEVEL_W+1:0] acc;
  logic                      rnz;
  logic signed [LEVEL_W-1:0] res;

  logic               div_start;
  div_status_t        div_stat;
  logic [DIV_W-1:0]   div_quo;
  logic [DIV_W-1:0]   div_rem;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign cfg_count  = (cfg_data[COUNT_W-1:0] > COUNT_MAX) ? COUNT_MAX : cfg_data[COUNT_W-1:0];
  assign rd_frame_x = {rd_frame[FRAME_W-1], rd_frame};

  bei_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (prod),
    .divisor   (den),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (in_accept && operation == OP_ANCHOR && int'(anchor_index) < MAX_ANCHORS) begin
      mem_frame[AW'(anchor_index)] <= anchor_frame;
      mem_level[AW'(anchor_index)] <= anchor_value;
    end
    if (rd_en) begin
      rd_frame <= mem_frame[rd_addr];
      rd_level <= mem_level[rd_addr];
    end
  end

  always_comb begin
    state_next       = state;
    cursor_prev_next = cursor_prev;
    cursor_next_next = cursor_next;
    rd_en            = 1'b0;
    rd_addr          = AW'(cursor_prev);
    div_start        = 1'b0;
    out_load         = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (operation == OP_ANCHOR) begin
            cursor_prev_next = '0;
            cursor_next_next = '0;
          end else begin
            // discontinuous block start rewinds the cursor
            if (block_start && have_history && $unsigned(frame) != expected_frame) begin
              cursor_prev_next = '0;
              cursor_next_next = '0;
            end
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (cursor_prev >= anchor_count) begin
          state_next = S_DONE;
        end else begin
          if (cursor_prev == cursor_next) cursor_next_next = cursor_next + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = AW'(cursor_prev);
          state_next = S_PREV;
        end
      end
      S_PREV: begin
        if (env < rd_frame_x) state_next = S_DONE;
        else                  state_next = S_WALK;
      end
      S_WALK: begin
        if (cursor_next >= anchor_count) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(cursor_next);
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (env >= rd_frame_x) begin
          cursor_prev_next = cursor_next;
          cursor_next_next = cursor_next + 1'b1;
          state_next       = S_WALK;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_DSTART;
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_FIX;
      end
      S_FIX:    state_next = S_ADJ;
      S_ADJ:    state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
    if (cfg_write && cfg_index == CFG_ANCHOR_COUNT) begin
      cursor_prev_next = '0;
      cursor_next_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cursor_prev    <= '0;
      cursor_next    <= '0;
      have_history   <= 1'b0;
      expected_frame <= '0;
      anchor_count   <= '0;
      frame_offset   <= '0;
      out_valid      <= 1'b0;
    end else begin
      state       <= state_next;
      cursor_prev <= cursor_prev_next;
      cursor_next <= cursor_next_next;
      if (in_accept) begin
        if (operation == OP_ANCHOR) begin
          have_history <= 1'b0;
        end else begin
          have_history   <= 1'b1;
          expected_frame <= $unsigned(frame) + 32'd1;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_ANCHOR_COUNT: begin
            anchor_count <= cfg_count;
            have_history <= 1'b0;
          end
          CFG_FRAME_OFFSET: frame_offset <= cfg_data;
          default: ;
        endcase
      end
      if (out_load)        out_valid <= 1'b1;
      else if (out_accept) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && operation == OP_SAMPLE) begin
      env <= {frame[FRAME_W-1], frame} - {frame_offset[FRAME_W-1], frame_offset};
    end
    case (state)
      S_START: res <= '0;
      S_PREV: begin
        fp  <= rd_frame;
        lp  <= rd_level;
        res <= rd_level;
      end
      S_NEXT: begin
        if (env >= rd_frame_x) begin
          fp  <= rd_frame;
          lp  <= rd_level;
          res <= rd_level;
        end else begin
          fn <= rd_frame;
          ln <= rd_level;
        end
      end
      S_MUL1: begin
        // true differences are below 2**32, so 32-bit wrap gives them exactly
        neg <= (ln < lp);
        mag <= (ln < lp) ? (lp[LEVEL_W-1:0] - ln[LEVEL_W-1:0])
                         : (ln[LEVEL_W-1:0] - lp[LEVEL_W-1:0]);
        num <= env[FRAME_W-1:0] - fp[FRAME_W-1:0];
        den <= fn[FRAME_W-1:0] - fp[FRAME_W-1:0];
      end
      S_MUL2: prod <= (2*DIV_W)'(mag) * (2*DIV_W)'(num);
      S_FIX: begin
        acc <= neg ? ({{2{lp[LEVEL_W-1]}}, lp} - {2'b00, div_quo})
                   : ({{2{lp[LEVEL_W-1]}}, lp} + {2'b00, div_quo});
        rnz <= (div_rem != '0);
      end
      S_ADJ: begin
        // step back toward zero when the division was inexact and the sum is of the opposite sign to the slope
        if (rnz && !neg && acc[LEVEL_W+1])
          res <= LEVEL_W'(acc + 2'sd1);
        else if (rnz && neg && !acc[LEVEL_W+1] && acc != '0)
          res <= LEVEL_W'(acc - 2'sd1);
        else
          res <= acc[LEVEL_W-1:0];
      end
      default: ;
    endcase
    if (out_load) level <= res;
  end

  assert property (@(posedge clk) disable iff (rst) cursor_prev <= anchor_count)
    else $error("cursor_prev beyond anchor_count");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_PREV) |-> (cursor_next > cursor_prev))
    else $error("cursor_next not ahead of cursor_prev");

  assert property (@(posedge clk) disable iff (rst) (state == S_MUL1) |-> (fn > fp))
    else $error("interpolation with non-increasing anchor frames");

  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst) div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

/* verif/breakpoint_envelope_interpolator_tb.sv */
// Testbench for breakpoint_envelope_interpolator: directed and random stimulus checked against a level predictor.
module breakpoint_envelope_interpolator_tb;
  import bei_pkg::*;

  localparam int MAX_SLOTS      = 16;
  localparam int RANDOM_REQS    = 600;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_CAP      = 100;

  localparam logic signed [FRAME_W-1:0] MAX_FRAME = 32'sh7fffffff;
  localparam logic signed [FRAME_W-1:0] MIN_FRAME = 32'sh80000000;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic                      op;
    logic signed [FRAME_W-1:0] frame;
    logic                      bstart;
    logic [SLOT_W-1:0]         slot;
    logic signed [FRAME_W-1:0] afr;
    logic signed [LEVEL_W-1:0] aval;
  } env_req_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [0:0]                cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      operation = OP_SAMPLE;
  logic signed [FRAME_W-1:0] frame = '0;
  logic                      block_start = 1'b0;
  logic [SLOT_W-1:0]         anchor_index = '0;
  logic signed [FRAME_W-1:0] anchor_frame = '0;
  logic signed [LEVEL_W-1:0] anchor_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [LEVEL_W-1:0] level;

  breakpoint_envelope_interpolator #(.MAX_ANCHORS(MAX_SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .frame(frame), .block_start(block_start),
    .anchor_index(anchor_index), .anchor_frame(anchor_frame), .anchor_value(anchor_value),
    .out_valid(out_valid), .out_stall(out_stall), .level(level)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // predictor state
  longint                    tbl_frame[MAX_SLOTS];
  longint                    tbl_level[MAX_SLOTS];
  int                        cur_lo = 0;
  int                        cur_hi = 0;
  logic                      seen_sample = 1'b0;
  logic [FRAME_W-1:0]        next_frame_due = '0;
  int                        n_anchors = 0;
  longint                    offset_reg = 0;

  env_req_t                  pending_reqs[$];
  logic signed [LEVEL_W-1:0] levels_due[$];
  env_req_t                  next_req;
  logic signed [LEVEL_W-1:0] want_level;
  logic                      req_taken = 1'b0;
  logic                      no_gaps = 1'b0;
  logic signed [FRAME_W-1:0] plan_offset = '0;
  int                        in_gap = 0;
  int                        stall_left = 0;
  int                        quiet_cycles = 0;
  int                        n_fail = 0;

  task automatic report_mismatch(input string msg);
    if (n_fail < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    n_fail++;
  endtask

  // Level for one sample request; advances the cursor like the block does.
  function automatic logic signed [LEVEL_W-1:0] envelope_level(
      input logic signed [FRAME_W-1:0] fr, input logic bs);
    longint env, lo_lvl, diff, acc;
    u64_t   mag, prod, den;
    env = longint'(fr) - offset_reg;
    if (bs && seen_sample && fr != next_frame_due) begin
      cur_lo = 0;
      cur_hi = 0;
    end
    seen_sample    = 1'b1;
    next_frame_due = fr + 1;
    if (cur_lo >= n_anchors) return '0;
    if (cur_lo == cur_hi) cur_hi++;
    if (env < tbl_frame[cur_lo]) return tbl_level[cur_lo][LEVEL_W-1:0];
    while (cur_hi < n_anchors && env >= tbl_frame[cur_hi]) begin
      cur_lo = cur_hi;
      cur_hi++;
    end
    if (cur_hi >= n_anchors) return tbl_level[cur_lo][LEVEL_W-1:0];
    lo_lvl = tbl_level[cur_lo];
    diff   = tbl_level[cur_hi] - lo_lvl;
    mag    = u64_t'(diff < 0 ? -diff : diff);
    prod   = mag * u64_t'(env - tbl_frame[cur_lo]);
    den    = u64_t'(tbl_frame[cur_hi] - tbl_frame[cur_lo]);
    acc    = (diff < 0) ? lo_lvl - longint'(prod / den) : lo_lvl + longint'(prod / den);
    // quotient magnitude was floored; pull back toward zero when the sum is of the opposite sign to the slope
    if (prod % den != 0) begin
      if (diff >= 0 && acc < 0) acc++;
      else if (diff < 0 && acc > 0) acc--;
    end
    return acc[LEVEL_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9, 0))
      0: return MIN_FRAME;
      1: return MAX_FRAME;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_sample(input logic signed [FRAME_W-1:0] fr, input logic bs);
    env_req_t r;
    r.op     = OP_SAMPLE;
    r.frame  = fr;
    r.bstart = bs;
    r.slot   = SLOT_W'($urandom);
    r.afr    = $urandom;
    r.aval   = $urandom;
    pending_reqs.push_back(r);
  endtask

  task automatic push_anchor(input logic [SLOT_W-1:0] slot, input logic signed [FRAME_W-1:0] fr,
                             input logic signed [LEVEL_W-1:0] val);
    env_req_t r;
    r.op     = OP_ANCHOR;
    r.frame  = $urandom;
    r.bstart = 1'($urandom);
    r.slot   = slot;
    r.afr    = fr;
    r.aval   = val;
    pending_reqs.push_back(r);
  endtask

  // wait for all words to be sent and all levels back, then let the block settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || levels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        in_valid     <= 1'b1;
        operation    <= next_req.op;
        frame        <= next_req.frame;
        block_start  <= next_req.bstart;
        anchor_index <= next_req.slot;
        anchor_frame <= next_req.afr;
        anchor_value <= next_req.aval;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // monitor: checks levels, tracks register and table writes
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (levels_due.size() == 0) begin
          report_mismatch($sformatf("level %0d with no request pending", level));
        end else begin
          want_level = levels_due.pop_front();
          if (level !== want_level)
            report_mismatch($sformatf("level %0d, want %0d", level, want_level));
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_ANCHOR_COUNT) begin
          n_anchors = (cfg_data[COUNT_W-1:0] > MAX_SLOTS) ? MAX_SLOTS : cfg_data[COUNT_W-1:0];
          cur_lo = 0;
          cur_hi = 0;
          seen_sample = 1'b0;
        end else begin
          offset_reg = longint'(signed'(cfg_data));
        end
      end
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        if (operation == OP_ANCHOR) begin
          tbl_frame[anchor_index] = longint'(anchor_frame);
          tbl_level[anchor_index] = longint'(anchor_value);
          cur_lo = 0;
          cur_hi = 0;
          seen_sample = 1'b0;
        end else begin
          levels_due.push_back(envelope_level(frame, block_start));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    longint                    env, f;
    longint                    plan_f[MAX_SLOTS];
    int                        slot_order[MAX_SLOTS];
    int                        n, gap_max, n_samp, blen, j, k, t, pushed;
    logic                      bs, first;
    logic [CFG_W-1:0]          cw;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every level is zero
    push_sample('0, 1'b1);
    push_sample(MAX_FRAME, 1'b0);
    push_sample(MIN_FRAME, 1'b1);
    push_anchor(4'd0, MIN_FRAME, MAX_FRAME);
    push_anchor(4'd1, -32'sd10, MIN_FRAME);
    push_anchor(4'd2, 32'sd1000, 32'sd7);
    push_anchor(4'd3, MAX_FRAME, -32'sd5);
    wait_drained();
    write_reg(CFG_ANCHOR_COUNT, 32'd4);
    push_sample(MIN_FRAME, 1'b1);
    push_sample(-32'sd20, 1'b0);
    push_sample(-32'sd10, 1'b0);
    push_sample(32'sd500, 1'b0);
    push_sample(-32'sd100, 1'b0);             // behind the cursor
    push_sample(MAX_FRAME, 1'b0);             // at the last anchor
    push_sample(MIN_FRAME, 1'b1);             // frame wraps: still continuous
    push_sample(MIN_FRAME + 32'sd5, 1'b1);    // jump: cursor rewinds
    push_sample(MIN_FRAME + 32'sd6, 1'b1);
    wait_drained();
    write_reg(CFG_FRAME_OFFSET, MIN_FRAME);
    push_sample(MAX_FRAME, 1'b1);
    wait_drained();
    write_reg(CFG_FRAME_OFFSET, MAX_FRAME);
    push_sample(MIN_FRAME, 1'b1);
    wait_drained();
    plan_offset = MAX_FRAME;

    pushed = 0;
    first  = 1'b1;
    while (pushed < RANDOM_REQS) begin
      no_gaps = ($urandom_range(3, 0) == 0);
      n = (first || $urandom_range(3, 0) == 0) ? MAX_SLOTS : $urandom_range(MAX_SLOTS, 1);
      case ($urandom_range(9, 0))
        0, 1: gap_max = 1 << 27;
        2, 3, 4: gap_max = 300;
        default: gap_max = 6;
      endcase
      f = longint'(rand_word());
      if (f + longint'(n) * gap_max > MAX_FRAME) f = MAX_FRAME - longint'(n) * gap_max;
      for (k = 0; k < n; k++) begin
        plan_f[k] = f;
        f += $urandom_range(gap_max, 1);
        slot_order[k] = k;
      end
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(k, 0);
        t = slot_order[k];
        slot_order[k] = slot_order[j];
        slot_order[j] = t;
      end
      if ($urandom_range(9, 0) == 0) plan_f[$urandom_range(n - 1, 0)] = rand_word();
      for (k = 0; k < n; k++)
        push_anchor(SLOT_W'(slot_order[k]), plan_f[slot_order[k]], rand_word());
      pushed += n;
      first = 1'b0;
      wait_drained();

      cw = $urandom;
      if ($urandom_range(9, 0) < 7) cw[COUNT_W-1:0] = COUNT_W'(n);
      write_reg(CFG_ANCHOR_COUNT, cw);
      t = $urandom_range(9, 0);
      if (t >= 5) begin
        plan_offset = (t < 8) ? $signed($urandom_range(8191, 0)) - 32'sd4096 : rand_word();
        write_reg(CFG_FRAME_OFFSET, plan_offset);
      end

      // sample walk: runs of consecutive frames, mostly block starts between runs, stray anchors and samples mixed in
      n_samp = $urandom_range(70, 25);
      env    = plan_f[0] - int'($urandom_range(4, 0));
      bs     = 1'b1;
      blen   = $urandom_range(12, 1);
      for (k = 0; k < n_samp; k++) begin
        t = $urandom_range(99, 0);
        if (t < 3) begin
          push_anchor(SLOT_W'($urandom), rand_word(), rand_word());
        end else if (t < 6) begin
          push_sample(rand_word(), 1'($urandom_range(1, 0)));
        end else begin
          push_sample(FRAME_W'(env + plan_offset), bs);
          env++;
          bs = 1'b0;
          blen--;
          if (blen == 0) begin
            blen = $urandom_range(12, 1);
            bs   = 1'b1;
            t    = $urandom_range(99, 0);
            if (t < 15) begin
              env += $urandom_range(2 * gap_max, 1);
            end else if (t < 25) begin
              env = plan_f[0] - int'($urandom_range(4, 0));
            end else if (t < 30) begin
              env += $urandom_range(2 * gap_max, 1);
              bs = 1'b0;
            end
            if (env > plan_f[n - 1] + 4) env = plan_f[0] - int'($urandom_range(4, 0));
          end
        end
        pushed++;
      end
      wait_drained();
    end

    if (n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
